@@ src/tlbpd_pkg.sv @@
// Shared types and constants for the text line and binary packet deframer
// No dependencies; used by tlbpd_out_if and by all deframer modules
`default_nettype none

package tlbpd_pkg;

  // width of the timeout register
  localparam int unsigned TimeoutBits = 24;

  // line terminators and prefix bytes
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] PrefixB0  = 8'h00;
  localparam logic [7:0] PrefixB1  = 8'h01;

  // input item actions
  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  // result kinds
  typedef enum logic [2:0] {
    KIND_TEXT     = 3'd0,
    KIND_LINE_END = 3'd1,
    KIND_DISCARD  = 3'd2,
    KIND_PACKET   = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_e;

  // one result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_out;
    logic       last;
  } result_t;

  // results produced by one accepted item, up to two
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

@@ src/tlbpd_in_if.sv @@
// Input channel of the deframer: one byte or one tick per transfer
// Depends on tlbpd_pkg for the action codes only by convention
`default_nettype none

interface tlbpd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

@@ src/tlbpd_out_if.sv @@
// Output channel of the deframer: one result item per transfer
// Depends on tlbpd_pkg for the kind type
`default_nettype none

interface tlbpd_out_if;
  logic                valid;
  logic                ready;
  tlbpd_pkg::kind_e    kind;
  logic [7:0]          data_out;
  logic                last;

  modport source (output valid, output kind, output data_out, output last, input ready);
  modport sink   (input valid, input kind, input data_out, input last, output ready);
endinterface

`default_nettype wire

@@ src/tlbpd_core.sv @@
// Framing state and per-item decode of the deframer, timeout register included
// Depends on tlbpd_pkg for kinds, character constants and the push struct
`default_nettype none

module tlbpd_core #(
  parameter int unsigned TickBits = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              action_i,
  input  wire logic [7:0]                        data_byte_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [tlbpd_pkg::TimeoutBits-1:0] cfg_wdata_i,
  output tlbpd_pkg::push_t                       push_o
);

  localparam int unsigned CmpBits =
    (TickBits > tlbpd_pkg::TimeoutBits) ? TickBits : tlbpd_pkg::TimeoutBits;

  typedef enum logic [1:0] {
    PS_NONE  = 2'd0,
    PS_ZERO  = 2'd1,
    PS_ONE   = 2'd2,
    PS_LENLO = 2'd3
  } prefix_e;

  logic [tlbpd_pkg::TimeoutBits-1:0] timeout_q;
  logic [TickBits-1:0]               idle_q, idle_d;
  prefix_e                           stage_q, stage_d;
  logic                              in_packet_q, in_packet_d;
  logic                              line_open_q, line_open_d;
  logic [7:0]                        length_low_q, length_low_d;
  logic [15:0]                       bytes_left_q, bytes_left_d;

  logic                              timed_out;
  logic                              completed;
  logic [1:0]                        scnt;
  tlbpd_pkg::result_t                s0, s1;
  tlbpd_pkg::result_t                disc;

  assign timed_out = (timeout_q != '0) && (CmpBits'(idle_q) > CmpBits'(timeout_q));
  assign disc      = '{kind: tlbpd_pkg::KIND_DISCARD, data_out: 8'h00, last: 1'b0};

  // decode of one accepted item
  always_comb begin
    idle_d       = idle_q;
    stage_d      = stage_q;
    in_packet_d  = in_packet_q;
    line_open_d  = line_open_q;
    length_low_d = length_low_q;
    bytes_left_d = bytes_left_q;
    completed    = 1'b0;
    scnt         = 2'd0;
    s0           = disc;
    s1           = disc;
    push_o       = '{cnt: 2'd0, r0: disc, r1: disc};

    if (accept_i) begin
      if (action_i == tlbpd_pkg::ActTick) begin
        // saturating idle counter
        if (idle_q != '1) begin
          idle_d = idle_q + 1'b1;
        end
      end else begin
        idle_d = '0;
        // timeout voids framing state first
        if (timed_out) begin
          line_open_d  = 1'b0;
          in_packet_d  = 1'b0;
          bytes_left_d = '0;
          stage_d      = PS_NONE;
        end

        if (in_packet_d) begin
          // payload byte
          s0           = '{kind: tlbpd_pkg::KIND_PACKET, data_out: data_byte_i,
                           last: (bytes_left_d == 16'd1)};
          scnt         = 2'd1;
          bytes_left_d = bytes_left_d - 16'd1;
          if (bytes_left_d == '0) begin
            in_packet_d = 1'b0;
            line_open_d = 1'b0;
            stage_d     = PS_NONE;
          end
        end else begin
          if (!line_open_d) begin
            stage_d = PS_NONE;
          end
          // prefix matcher
          unique case (stage_d)
            PS_NONE: begin
              if (data_byte_i == tlbpd_pkg::PrefixB0) begin
                stage_d = PS_ZERO;
              end
            end
            PS_ZERO: begin
              stage_d = (data_byte_i == tlbpd_pkg::PrefixB1) ? PS_ONE : PS_NONE;
            end
            PS_ONE: begin
              length_low_d = data_byte_i;
              stage_d      = PS_LENLO;
            end
            PS_LENLO: begin
              bytes_left_d = {data_byte_i, length_low_q};
              stage_d      = PS_NONE;
              completed    = 1'b1;
            end
            default: begin
              stage_d = PS_NONE;
            end
          endcase

          priority if (completed) begin
            // prefix done: void the line, open the packet, or report an empty one if the length is zero
            s0          = disc;
            line_open_d = 1'b0;
            if (bytes_left_d == '0) begin
              s1          = '{kind: tlbpd_pkg::KIND_EMPTY, data_out: 8'h00, last: 1'b0};
              scnt        = 2'd2;
              in_packet_d = 1'b0;
            end else begin
              scnt        = 2'd1;
              in_packet_d = 1'b1;
            end
          end else if ((stage_d == PS_NONE) &&
                       ((data_byte_i == tlbpd_pkg::CharCr) ||
                        (data_byte_i == tlbpd_pkg::CharLf))) begin
            // line end, empty lines skipped
            if (line_open_d) begin
              s0          = '{kind: tlbpd_pkg::KIND_LINE_END, data_out: 8'h00, last: 1'b0};
              scnt        = 2'd1;
              line_open_d = 1'b0;
            end
          end else begin
            s0          = '{kind: tlbpd_pkg::KIND_TEXT, data_out: data_byte_i, last: 1'b0};
            scnt        = 2'd1;
            line_open_d = 1'b1;
          end
        end

        // merge the timeout discard in front
        if (timed_out && (line_open_q || in_packet_q)) begin
          push_o = '{cnt: scnt + 2'd1, r0: disc, r1: s0};
        end else begin
          push_o = '{cnt: scnt, r0: s0, r1: s1};
        end
      end
    end
  end

  // framing state and timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= '0;
      idle_q       <= '0;
      stage_q      <= PS_NONE;
      in_packet_q  <= 1'b0;
      line_open_q  <= 1'b0;
      length_low_q <= '0;
      bytes_left_q <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      idle_q       <= idle_d;
      stage_q      <= stage_d;
      in_packet_q  <= in_packet_d;
      line_open_q  <= line_open_d;
      length_low_q <= length_low_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

`default_nettype wire

@@ src/tlbpd_out_fifo.sv @@
// Two-entry result register: takes up to two results per cycle, gives one
// Depends on tlbpd_pkg for the result and push structs
`default_nettype none

module tlbpd_out_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire tlbpd_pkg::push_t push_i,
  input  wire logic         pop_i,
  output tlbpd_pkg::result_t head_o,
  output logic              valid_o,
  output logic              room_o
);

  logic [1:0]         cnt_q, cnt_d, cnt_mid;
  tlbpd_pkg::result_t ent_q [2];
  tlbpd_pkg::result_t ent_d [2];

  assign head_o  = ent_q[0];
  assign valid_o = (cnt_q != 2'd0);
  // room for two results after this cycle's transfer
  assign room_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_i);

  // shift out on transfer, then append
  always_comb begin
    cnt_mid  = cnt_q - {1'b0, pop_i};
    ent_d[0] = pop_i ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    if (cnt_mid == 2'd0) begin
      ent_d[0] = push_i.r0;
      ent_d[1] = push_i.r1;
    end else if (push_i.cnt != 2'd0) begin
      ent_d[1] = push_i.r0;
    end
    cnt_d = cnt_mid + push_i.cnt;
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // entries, payload only
  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule

`default_nettype wire

@@ src/text_line_and_binary_packet_deframer.sv @@
// Results are registered: a result is offered in the cycle after the transfer of the item that caused it.
// Throughput: one item per cycle while the output is ready and each item gives at most one result;
//   an item with two results holds the input while the two-entry result register drains.
// Reset: asynchronous, active low; clears framing state, idle counter and the timeout
//   register, which reads zero (timeout disabled) until written.
// Depends on tlbpd_pkg, tlbpd_in_if, tlbpd_out_if, tlbpd_core and tlbpd_out_fifo
`default_nettype none

module text_line_and_binary_packet_deframer #(
  parameter int unsigned TICK_COUNTER_BITS = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  tlbpd_in_if.sink                               in_i,
  tlbpd_out_if.source                            out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tlbpd_pkg::TimeoutBits-1:0] cfg_wdata_i
);

  logic               room;
  logic               accept;
  logic               pop;
  logic               head_valid;
  tlbpd_pkg::push_t   push;
  tlbpd_pkg::result_t head;

  // handshakes
  assign in_i.ready = room;
  assign accept     = in_i.valid & room;
  assign pop        = head_valid & out_o.ready;

  // item decode and framing state
  tlbpd_core #(
    .TickBits (TICK_COUNTER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (in_i.action),
    .data_byte_i (in_i.data_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push)
  );

  // result register
  tlbpd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .room_o  (room)
  );

  assign out_o.valid    = head_valid;
  assign out_o.kind     = head.kind;
  assign out_o.data_out = head.data_out;
  assign out_o.last     = head.last;

endmodule

`default_nettype wire
